// File: design/multi_queue_urgent_front_insert_unit_defines.svh
// Assertion macros used by the queue bank back end (mqufi_back).
`ifndef MULTI_QUEUE_URGENT_FRONT_INSERT_UNIT_DEFINES_SVH
`define MULTI_QUEUE_URGENT_FRONT_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MQUFI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQUFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/mqufi_pkg.sv
package mqufi_pkg;

   localparam int NUM_QUEUES  = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int ID_BITS     = 16;

   // Fixed port widths.
   localparam int SEL_W       = 4;
   localparam int IN_ID_W     = 16;
   localparam int OUT_ID_W    = 16;
   localparam int NEW_COUNT_W = 4;
   localparam int CODE_W      = 2;

   localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int ENTRY_W   = ID_BITS + 1;

   // Command queue between the front and back parts.
   localparam int FIFO_DEPTH = 2;
   localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FFILL_W    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_ADD_TAIL    = 3'd0,
      CMD_ADD_HEAD    = 3'd1,
      CMD_TAKE        = 3'd2,
      CMD_REJECT_ADD  = 3'd3,
      CMD_REJECT_TAKE = 3'd4
   } cmd_kind_type;

   typedef enum logic [CODE_W-1:0] {
      RC_DONE  = 2'd0,
      RC_FULL  = 2'd1,
      RC_EMPTY = 2'd2
   } result_code_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [QIDX_W-1:0]   qidx;
      logic [ID_BITS-1:0]  id;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } fifo_status_type;

endpackage

// File: design/mqufi_front.sv
module mqufi_front import mqufi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [SEL_W-1:0]   req_queue_sel,
   input  logic               req_urgent,
   input  logic [IN_ID_W-1:0] req_item_id,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  logic               cmd_taken
);

   logic    cmd_valid_ff;
   logic    cmd_valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   cmd_type decoded;
   logic    accept;
   logic    queue_exists;

   // The holding register stalls the requester only while it cannot drain.
   assign req_stall = cmd_valid_ff && !cmd_taken;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      queue_exists = (int'(req_queue_sel) < NUM_QUEUES);
      decoded.qidx = QIDX_W'(req_queue_sel);
      decoded.id   = ID_BITS'(req_item_id);
      if (!queue_exists) begin
         decoded.kind = req_type ? CMD_REJECT_TAKE : CMD_REJECT_ADD;
      end else if (req_type) begin
         decoded.kind = CMD_TAKE;
      end else if (req_urgent) begin
         decoded.kind = CMD_ADD_HEAD;
      end else begin
         decoded.kind = CMD_ADD_TAIL;
      end
   end

   assign cmd_valid_in = accept || (cmd_valid_ff && !cmd_taken);
   assign cmd_in       = accept ? decoded : cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

// File: design/mqufi_cmd_fifo.sv
module mqufi_cmd_fifo import mqufi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_cmd,
   input  logic            pop,
   output cmd_type         head_cmd,
   output fifo_status_type status
);

   cmd_type             slot_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]   wr_ptr_ff;
   logic [FPTR_W-1:0]   wr_ptr_in;
   logic [FPTR_W-1:0]   rd_ptr_ff;
   logic [FPTR_W-1:0]   rd_ptr_in;
   logic [FFILL_W-1:0]  fill_ff;
   logic [FFILL_W-1:0]  fill_in;

   function automatic logic [FPTR_W-1:0] ptr_next(input logic [FPTR_W-1:0] p);
      return (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.valid = (fill_ff != '0);
   assign status.full  = (fill_ff == FFILL_W'(FIFO_DEPTH));
   assign head_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/mqufi_back.sv
`include "multi_queue_urgent_front_insert_unit_defines.svh"

module mqufi_back import mqufi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  fifo_status_type        fifo_status,
   input  cmd_type                head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CODE_W-1:0]      rsp_result_code,
   output logic [OUT_ID_W-1:0]    rsp_out_id,
   output logic                   rsp_out_urgent,
   output logic [NEW_COUNT_W-1:0] rsp_new_count
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } back_state_type;

   back_state_type     state_ff;
   back_state_type     state_in;

   // Per-queue bookkeeping: ring head pointer and fill count.
   logic [CNT_W-1:0]   count_ff [NUM_QUEUES];
   logic [PTR_W-1:0]   head_ff  [NUM_QUEUES];

   // Entry storage: urgent mark above the ID.
   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]   rd_cnt_ff;
   logic [CNT_W-1:0]   rd_cnt_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_code_type    rsp_code_ff;
   result_code_type    rsp_code_in;
   logic [ID_BITS-1:0] rsp_id_ff;
   logic [ID_BITS-1:0] rsp_id_in;
   logic               rsp_urg_ff;
   logic               rsp_urg_in;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic [CNT_W-1:0]   rsp_cnt_in;

   logic [CNT_W-1:0]   cur_cnt;
   logic [PTR_W-1:0]   cur_head;
   logic               is_full;
   logic               is_empty;
   logic [PTR_W:0]     tail_sum;
   logic [PTR_W-1:0]   tail_slot;
   logic [PTR_W-1:0]   head_dec;
   logic [PTR_W-1:0]   head_inc;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic               count_we;
   logic [CNT_W-1:0]   count_new;
   logic               head_we;
   logic [PTR_W-1:0]   head_new;
   logic               rsp_load;
   logic               out_free;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                   input logic [PTR_W-1:0] s);
      return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(s);
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && fifo_status.valid && out_free;

   always_comb begin
      cur_cnt   = count_ff[head_cmd.qidx];
      cur_head  = head_ff[head_cmd.qidx];
      is_full   = (cur_cnt >= CNT_W'(QUEUE_DEPTH));
      is_empty  = (cur_cnt == '0);
      tail_sum  = {1'b0, cur_head} + (PTR_W + 1)'(cur_cnt);
      tail_slot = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
                  PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
      head_dec  = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
      head_inc  = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      mem_we      = 1'b0;
      mem_wr_addr = slot_addr(head_cmd.qidx, tail_slot);
      mem_wr_data = {1'b0, head_cmd.id};
      mem_re      = 1'b0;
      mem_rd_addr = slot_addr(head_cmd.qidx, cur_head);
      count_we    = 1'b0;
      count_new   = cur_cnt;
      head_we     = 1'b0;
      head_new    = cur_head;
      rd_cnt_in   = rd_cnt_ff;
      rsp_load    = 1'b0;
      rsp_code_in = RC_DONE;
      rsp_id_in   = '0;
      rsp_urg_in  = 1'b0;
      rsp_cnt_in  = '0;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               case (head_cmd.kind)
                  CMD_ADD_TAIL: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_code_in = RC_FULL;
                        rsp_cnt_in  = cur_cnt;
                     end else begin
                        mem_we     = 1'b1;
                        count_we   = 1'b1;
                        count_new  = cur_cnt + 1'b1;
                        rsp_cnt_in = count_new;
                     end
                  end
                  CMD_ADD_HEAD: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_code_in = RC_FULL;
                        rsp_cnt_in  = cur_cnt;
                     end else begin
                        mem_we      = 1'b1;
                        mem_wr_addr = slot_addr(head_cmd.qidx, head_dec);
                        mem_wr_data = {1'b1, head_cmd.id};
                        head_we     = 1'b1;
                        head_new    = head_dec;
                        count_we    = 1'b1;
                        count_new   = cur_cnt + 1'b1;
                        rsp_cnt_in  = count_new;
                     end
                  end
                  CMD_TAKE: begin
                     if (is_empty) begin
                        rsp_load    = 1'b1;
                        rsp_code_in = RC_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        head_we   = 1'b1;
                        head_new  = head_inc;
                        count_we  = 1'b1;
                        count_new = cur_cnt - 1'b1;
                        rd_cnt_in = count_new;
                        state_in  = S_READ;
                     end
                  end
                  CMD_REJECT_ADD: begin
                     rsp_load    = 1'b1;
                     rsp_code_in = RC_FULL;
                  end
                  CMD_REJECT_TAKE: begin
                     rsp_load    = 1'b1;
                     rsp_code_in = RC_EMPTY;
                  end
                  default: begin
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            // The head entry read at the pop edge is now in rd_data_ff.
            rsp_load   = 1'b1;
            rsp_id_in  = rd_data_ff[ID_BITS-1:0];
            rsp_urg_in = rd_data_ff[ID_BITS];
            rsp_cnt_in = rd_cnt_ff;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (count_we) begin
            count_ff[head_cmd.qidx] <= count_new;
         end
         if (head_we) begin
            head_ff[head_cmd.qidx] <= head_new;
         end
      end
      rd_cnt_ff <= rd_cnt_in;
      if (rsp_load) begin
         rsp_code_ff <= rsp_code_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_urg_ff  <= rsp_urg_in;
         rsp_cnt_ff  <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_out_id      = OUT_ID_W'(rsp_id_ff);
   assign rsp_out_urgent  = rsp_urg_ff;
   assign rsp_new_count   = NEW_COUNT_W'(rsp_cnt_ff);

   `MQUFI_ASSERT_IMPL(a_read_slot_free, clock, reset, state_ff == S_READ, !rsp_valid_ff, "output register busy while a take waits for memory")
   `MQUFI_ASSERT_NEXT(a_result_follows, clock, reset, pop, rsp_valid_ff || state_ff == S_READ, "popped command produced no result")
   `MQUFI_ASSERT_IMPL(a_one_mem_op, clock, reset, mem_we, !mem_re, "memory written and read in one cycle")
   `MQUFI_ASSERT_IMPL(a_count_bound, clock, reset, count_we, count_new <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// File: design/multi_queue_urgent_front_insert_unit.sv
// Bank of bounded queues with urgent insertion at the head.
// Request channel (req_valid / req_stall): req_type 0 adds req_item_id to queue
// req_queue_sel, at the tail, or at the head when req_urgent is set; req_type 1
// takes the head entry out. A queue number with no queue behind it is answered
// as full for an add and empty for a take, and changes nothing.
// Response channel (rsp_valid / rsp_stall): exactly one response per request, in
// request order, with the result code, the ID and urgent mark taken (zero
// otherwise) and the addressed queue's count after the request.
// Adds and failed takes are answered from the popped command; a successful take
// is answered after the registered read of the entry memory, in S_READ. The back
// end retires one add per cycle while its output is free, but takes no new command
// while a take waits for that read. A two-entry command queue lets the front
// accept requests while the back end works or is held.
// When the receiver stalls, the response holds, the back end stops at its next
// command, and the command queue and front register fill before req_stall rises.
// Reset clears all queue counts and head pointers at once; entries need no
// clearing because only entries that were written are ever read.
module multi_queue_urgent_front_insert_unit import mqufi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic [SEL_W-1:0]       req_queue_sel,
   input  logic                   req_urgent,
   input  logic [IN_ID_W-1:0]     req_item_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CODE_W-1:0]      rsp_result_code,
   output logic [OUT_ID_W-1:0]    rsp_out_id,
   output logic                   rsp_out_urgent,
   output logic [NEW_COUNT_W-1:0] rsp_new_count
);

   logic            front_valid;
   cmd_type         front_cmd;
   logic            front_taken;
   cmd_type         fifo_head;
   fifo_status_type fifo_status;
   logic            back_pop;

   // A decoded command moves into the queue whenever the queue has room.
   assign front_taken = front_valid && !fifo_status.full;

   mqufi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_queue_sel (req_queue_sel),
      .req_urgent    (req_urgent),
      .req_item_id   (req_item_id),
      .cmd_valid     (front_valid),
      .cmd           (front_cmd),
      .cmd_taken     (front_taken)
   );

   mqufi_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (front_taken),
      .push_cmd (front_cmd),
      .pop      (back_pop),
      .head_cmd (fifo_head),
      .status   (fifo_status)
   );

   mqufi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_status     (fifo_status),
      .head_cmd        (fifo_head),
      .pop             (back_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_code (rsp_result_code),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_urgent  (rsp_out_urgent),
      .rsp_new_count   (rsp_new_count)
   );

endmodule
